/* hw/rtl/stc_pkg.sv */
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types, codes and helpers of the scalar type conversion core.
// ----------------------------------------------------------------------------
package stc_pkg;

    // Source type codes
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_INT    = 2'd1;
    localparam logic [1:0] KIND_SINGLE = 2'd2;
    localparam logic [1:0] KIND_DOUBLE = 2'd3;

    // Largest finite single, as a double magnitude
    localparam logic [62:0] FLT_MAX_DBL = 63'h47EFFFFFE0000000;

    // Stage 1: decoded source
    typedef struct packed {
        logic [1:0]  kind;
        logic        sign;
        logic [31:0] nmag;   // magnitude to normalize
        logic [4:0]  lz;     // leading zeros of nmag
        logic [63:0] raw;
    } s1_t;

    // Stage 2: value in double format
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] fraw;
        logic [63:0] dbits;
    } s2_t;

    // Stage 3: aligned float and int parts
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] fraw;
        logic [63:0] dbits;
        logic        sign;
        logic        is_nan;
        logic        is_inf;
        logic        le_max;
        logic        fzero;
        logic [7:0]  fexp;
        logic [23:0] keep;
        logic        inc;
        logic        int_ok;
        logic        int_neg;
        logic [31:0] int_mag;
    } s3_t;

    // Stage 4: result
    typedef struct packed {
        logic        char_ok;
        logic [7:0]  char_value;
        logic        int_ok;
        logic [31:0] int_value;
        logic        float_ok;
        logic [31:0] float_bits;
        logic [63:0] double_bits;
    } s4_t;

    // Count leading zeros of a 32-bit word (0 for zero; callers skip zero)
    function automatic logic [4:0] lzc32(input logic [31:0] x);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
            begin
                n = 5'(31 - i);
            end
        end
        return n;
    endfunction

endpackage

/* hw/rtl/stc_norm.sv */
// ----------------------------------------------------------------------------
// stc_norm
// Decode the source type and normalize it into double format (two stages).
// ----------------------------------------------------------------------------
module stc_norm
    import stc_pkg::*;
(
    input  logic        clk,
    input  logic [1:0]  en,        // bit 0 loads stage 1, bit 1 loads stage 2
    input  logic [1:0]  req_type,
    input  logic [63:0] value,
    output s2_t         s2
);

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;

    // Decode sign and magnitude, count leading zeros
    always_comb
    begin
        logic [31:0] iv;
        logic [31:0] mag;
        iv = (req_type == KIND_CHAR) ? {{24{value[7]}}, value[7:0]} : value[31:0];
        mag = iv[31] ? (32'd0 - iv) : iv;
        s1_next.kind = req_type;
        s1_next.raw  = value;
        case (req_type)
            KIND_SINGLE: s1_next.sign = value[31];
            KIND_DOUBLE: s1_next.sign = value[63];
            default:     s1_next.sign = iv[31];
        endcase
        s1_next.nmag = (req_type == KIND_SINGLE) ? {9'd0, value[22:0]} : mag;
        s1_next.lz   = lzc32(s1_next.nmag);
    end

    // Normalize and build the double pattern
    always_comb
    begin
        logic [31:0] norm;
        logic [7:0]  e8;
        logic [22:0] m23;
        norm = s1_reg.nmag << s1_reg.lz;
        e8   = s1_reg.raw[30:23];
        m23  = s1_reg.raw[22:0];
        s2_next.kind = s1_reg.kind;
        s2_next.fraw = s1_reg.raw[31:0];
        case (s1_reg.kind)
            KIND_SINGLE:
            begin
                if (e8 == 8'hFF)
                begin
                    if (m23 == 23'd0)
                        s2_next.dbits = {s1_reg.sign, 11'h7FF, 52'd0};
                    else
                        s2_next.dbits = {s1_reg.sign, 11'h7FF, 1'b1, m23[21:0], 29'd0};
                end
                else if (e8 == 8'd0)
                begin
                    if (m23 == 23'd0)
                        s2_next.dbits = {s1_reg.sign, 63'd0};
                    else
                        s2_next.dbits = {s1_reg.sign, 11'(11'd905 - 11'(s1_reg.lz)),
                                         norm[30:0], 21'd0};
                end
                else
                begin
                    s2_next.dbits = {s1_reg.sign, 11'(11'(e8) + 11'd896), m23, 29'd0};
                end
            end
            KIND_DOUBLE:
            begin
                s2_next.dbits = s1_reg.raw;
            end
            default:
            begin
                if (s1_reg.nmag == 32'd0)
                    s2_next.dbits = 64'd0;
                else
                    s2_next.dbits = {s1_reg.sign, 11'(11'd1054 - 11'(s1_reg.lz)),
                                     norm[30:0], 21'd0};
            end
        endcase
    end

    // Advance stage registers
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_reg <= s1_next;
        end
        if (en[1])
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

/* hw/rtl/stc_round.sv */
// ----------------------------------------------------------------------------
// stc_round
// Round the double to single and extract the integer forms (two stages).
// ----------------------------------------------------------------------------
module stc_round
    import stc_pkg::*;
(
    input  logic       clk,
    input  logic [1:0] en,         // bit 0 loads stage 3, bit 1 loads stage 4
    input  s2_t        s2,
    output s4_t        s4
);

    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;

    // Align significand for single rounding and for the integer
    always_comb
    begin
        logic [10:0]  ex;
        logic [51:0]  m;
        logic [52:0]  sig;
        logic [10:0]  sh;
        logic [116:0] ext;
        logic [10:0]  fb;
        logic [105:0] ext2;
        ex  = s2.dbits[62:52];
        m   = s2.dbits[51:0];
        sig = {1'b1, m};
        sh  = 11'd926 - ex;
        ext = {sig, 64'd0} >> sh[5:0];
        fb  = 11'd1075 - ex;
        ext2 = {sig, 53'd0} >> fb[5:0];

        s3_next.kind   = s2.kind;
        s3_next.fraw   = s2.fraw;
        s3_next.dbits  = s2.dbits;
        s3_next.sign   = s2.dbits[63];
        s3_next.is_nan = (ex == 11'h7FF) && (m != 52'd0);
        s3_next.is_inf = (ex == 11'h7FF) && (m == 52'd0);
        s3_next.le_max = (s2.dbits[62:0] <= FLT_MAX_DBL);
        s3_next.fzero  = (ex == 11'd0);

        // Single: normal range rounds at bit 29, below it shifts further
        if (ex >= 11'd897)
        begin
            s3_next.fexp = 8'(ex - 11'd897);
            s3_next.keep = sig[52:29];
            s3_next.inc  = sig[28] && ((|sig[27:0]) || sig[29]);
        end
        else if (sh >= 11'd54)
        begin
            s3_next.fexp = 8'd0;
            s3_next.keep = 24'd0;
            s3_next.inc  = 1'b0;
        end
        else
        begin
            s3_next.fexp = 8'd0;
            s3_next.keep = ext[87:64];
            s3_next.inc  = ext[63] && ((|ext[62:0]) || ext[64]);
        end

        // Integer: integral values within range only
        s3_next.int_neg = s2.dbits[63];
        s3_next.int_ok  = 1'b0;
        s3_next.int_mag = 32'd0;
        if (ex == 11'd0)
        begin
            s3_next.int_ok = (m == 52'd0);
        end
        else if (ex == 11'h7FF || ex < 11'd1023)
        begin
            s3_next.int_ok = 1'b0;
        end
        else if (ex >= 11'd1054)
        begin
            if (s2.dbits[63] && ex == 11'd1054 && m == 52'd0)
            begin
                s3_next.int_ok  = 1'b1;
                s3_next.int_mag = 32'h8000_0000;
            end
        end
        else
        begin
            s3_next.int_ok  = ~(|ext2[52:0]);
            s3_next.int_mag = ext2[84:53];
        end
    end

    // Assemble the result forms
    always_comb
    begin
        logic [30:0] body;
        logic [31:0] iv;
        body = 31'({s3_reg.fexp, 23'd0}) + 31'(s3_reg.keep) + 31'(s3_reg.inc);
        if (s3_reg.kind == KIND_SINGLE)
        begin
            s4_next.float_ok   = 1'b1;
            s4_next.float_bits = s3_reg.fraw;
        end
        else if (s3_reg.is_nan)
        begin
            s4_next.float_ok   = 1'b1;
            s4_next.float_bits = {s3_reg.sign, 31'h7FC0_0000};
        end
        else if (s3_reg.is_inf)
        begin
            s4_next.float_ok   = 1'b1;
            s4_next.float_bits = {s3_reg.sign, 31'h7F80_0000};
        end
        else if (s3_reg.le_max)
        begin
            s4_next.float_ok   = 1'b1;
            s4_next.float_bits = s3_reg.fzero ? {s3_reg.sign, 31'd0} : {s3_reg.sign, body};
        end
        else
        begin
            s4_next.float_ok   = 1'b0;
            s4_next.float_bits = 32'd0;
        end

        if (!s3_reg.int_ok)
            iv = 32'd0;
        else if (s3_reg.int_neg)
            iv = 32'd0 - s3_reg.int_mag;
        else
            iv = s3_reg.int_mag;
        s4_next.int_ok      = s3_reg.int_ok;
        s4_next.int_value   = iv;
        s4_next.char_ok     = s3_reg.int_ok && ((iv[31:7] == 25'd0) || (&iv[31:7]));
        s4_next.char_value  = s4_next.char_ok ? iv[7:0] : 8'd0;
        s4_next.double_bits = s3_reg.dbits;
    end

    // Advance stage registers
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s3_reg <= s3_next;
        end
        if (en[1])
        begin
            s4_reg <= s4_next;
        end
    end

    assign s4 = s4_reg;

endmodule

/* hw/rtl/scalar_type_conversion_core.sv */
// ----------------------------------------------------------------------------
// scalar_type_conversion_core
// Converts one scalar among char, int32, IEEE single and IEEE double.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one scalar per transfer: s_tuser carries the
//   source type (char, int32, single, double), s_tdata the raw bits.
//   The master channel returns the value in all four forms; m_tuser holds
//   the valid flags of the char, int and single forms.
//   The accepting edge loads the first of four register stages (decode,
//   normalize to double, align, assemble); the result then moves through
//   the others in that order to m_tvalid.
//   One transfer is accepted every cycle while the output is taken.
//   When the receiver holds m_tready low, the result holds on m_tdata and
//   the stages behind it keep filling until all four hold data; then
//   s_tready falls. Nothing is dropped or repeated.
//   Reset clears all stage valid bits; the block is empty after reset.
// ----------------------------------------------------------------------------
module scalar_type_conversion_core
    import stc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // value[63:0]
    input  logic [1:0]   s_tuser,   // req_type[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // char_value[7:0], int_value[39:8],
                                    // float_bits[71:40], double_bits[135:72]
    output logic [2:0]   m_tuser    // char_ok[0], int_ok[1], float_ok[2]
);

    logic [3:0] vld_reg, vld_next;
    logic [3:0] en;
    s2_t        s2;
    s4_t        s4;

    // Load a stage when it is empty or its content moves on
    assign en[3] = !vld_reg[3] || m_tready;
    assign en[2] = !vld_reg[2] || en[3];
    assign en[1] = !vld_reg[1] || en[2];
    assign en[0] = !vld_reg[0] || en[1];

    always_comb
    begin
        vld_next[0] = en[0] ? s_tvalid   : vld_reg[0];
        vld_next[1] = en[1] ? vld_reg[0] : vld_reg[1];
        vld_next[2] = en[2] ? vld_reg[1] : vld_reg[2];
        vld_next[3] = en[3] ? vld_reg[2] : vld_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 4'd0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    stc_norm u_norm
    (
        .clk      (clk),
        .en       (en[1:0]),
        .req_type (s_tuser),
        .value    (s_tdata),
        .s2       (s2)
    );

    stc_round u_round
    (
        .clk (clk),
        .en  (en[3:2]),
        .s2  (s2),
        .s4  (s4)
    );

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[3];
    assign m_tdata  = {s4.double_bits, s4.float_bits, s4.int_value, s4.char_value};
    assign m_tuser  = {s4.float_ok, s4.int_ok, s4.char_ok};

endmodule

/* hw/rtl/stc_checker.sv */
// ----------------------------------------------------------------------------
// stc_checker
// Port-level checks of the scalar type conversion core.
// ----------------------------------------------------------------------------
module stc_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic [2:0]   m_tuser
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Char form valid only with int form valid
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[1])
        else $error("char valid without int valid");

    // Invalid int form reads zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> m_tdata[39:8] == 32'd0)
        else $error("invalid int not zero");

    // Invalid float form reads zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[2] |-> m_tdata[71:40] == 32'd0)
        else $error("invalid float not zero");

endmodule

bind scalar_type_conversion_core stc_checker u_stc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
